[design/igfrb_pkg.sv]
`default_nettype none
// ----------------------------------------------------------------------------
// Idle-gap frame ring buffer package
// Shared constants, command codes and state encoding for the frame buffer.
// ----------------------------------------------------------------------------
package igfrb_pkg;

  localparam int FRAME_BYTES_DEF = 1024;
  localparam int FRAME_SLOTS_DEF = 3;

  localparam int APB_ADDR_W = 2;
  localparam int APB_DATA_W = 32;
  localparam int TICK_W     = 8;
  localparam int FLEN_W     = 10;
  localparam int BYTE_W     = 8;

  localparam logic [APB_ADDR_W-1:0] ADDR_IDLE_TICKS = 2'd0;
  localparam logic [TICK_W-1:0]     IDLE_TICKS_RST  = 8'd4;

  typedef enum logic [1:0] {
    CMD_BYTE  = 2'd0,
    CMD_TICK  = 2'd1,
    CMD_READ  = 2'd2,
    CMD_CLEAR = 2'd3
  } cmd_t;

  typedef enum logic {
    ST_IDLE = 1'b0,
    ST_READ = 1'b1
  } state_t;

endpackage : igfrb_pkg
`default_nettype wire

[design/igfrb_regs.sv]
`default_nettype none
// ----------------------------------------------------------------------------
// Frame buffer configuration registers
// APB-style register file holding the idle gap length in timer ticks.
// ----------------------------------------------------------------------------
module igfrb_regs (
  input  wire logic                               clk,
  input  wire logic                               rst_n,
  input  wire logic                               psel,
  input  wire logic                               penable,
  input  wire logic                               pwrite,
  input  wire logic [igfrb_pkg::APB_ADDR_W-1:0]   paddr,
  input  wire logic [igfrb_pkg::APB_DATA_W-1:0]   pwdata,
  output logic      [igfrb_pkg::APB_DATA_W-1:0]   prdata,
  output logic                                    pready,
  output logic      [igfrb_pkg::TICK_W-1:0]       idle_ticks
);
  import igfrb_pkg::*;

  logic [TICK_W-1:0] idle_ticks_r;
  logic [TICK_W-1:0] idle_ticks_nxt;
  logic              wr_en;

  assign pready = 1'b1;
  assign wr_en  = psel && penable && pwrite && pready && (paddr == ADDR_IDLE_TICKS);

  always_comb begin
    idle_ticks_nxt = idle_ticks_r;
    if (wr_en) begin
      idle_ticks_nxt = pwdata[TICK_W-1:0];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      idle_ticks_r <= IDLE_TICKS_RST;
    end else begin
      idle_ticks_r <= idle_ticks_nxt;
    end
  end

  always_comb begin
    prdata = '0;
    if (paddr == ADDR_IDLE_TICKS) begin
      prdata = {{(APB_DATA_W-TICK_W){1'b0}}, idle_ticks_r};
    end
  end

  assign idle_ticks = idle_ticks_r;

endmodule : igfrb_regs
`default_nettype wire

[design/idle_gap_frame_ring_buffer.sv]
`default_nettype none
// ----------------------------------------------------------------------------
// Idle-gap frame ring buffer
// Groups received bytes into frames separated by idle gaps and hands out the
// oldest completed frame one byte per read command.
// ----------------------------------------------------------------------------
// Each command word yields exactly one result word. Byte, tick and clear
// commands load the output register directly; a read first passes the read
// state, as the frame byte comes from the registered slot memory read port.
// A new command word is taken only when the output register is empty or its
// result word leaves in the same cycle, so in_ready stays low while a result
// word waits and in the read state. The slot memory needs no clearing pass
// after reset: only bytes written since the last clear are ever read back.
module idle_gap_frame_ring_buffer #(
  parameter int FRAME_BYTES = igfrb_pkg::FRAME_BYTES_DEF,
  parameter int FRAME_SLOTS = igfrb_pkg::FRAME_SLOTS_DEF
) (
  input  wire logic                               clk,
  input  wire logic                               rst_n,
  input  wire logic                               psel,
  input  wire logic                               penable,
  input  wire logic                               pwrite,
  input  wire logic [igfrb_pkg::APB_ADDR_W-1:0]   paddr,
  input  wire logic [igfrb_pkg::APB_DATA_W-1:0]   pwdata,
  output logic      [igfrb_pkg::APB_DATA_W-1:0]   prdata,
  output logic                                    pready,
  input  wire logic                               in_valid,
  output logic                                    in_ready,
  input  wire logic [1:0]                         in_cmd,
  input  wire logic [igfrb_pkg::BYTE_W-1:0]       in_rx_byte,
  output logic                                    out_valid,
  input  wire logic                               out_ready,
  output logic                                    out_frame_ready,
  output logic      [igfrb_pkg::BYTE_W-1:0]       out_read_byte,
  output logic      [igfrb_pkg::FLEN_W-1:0]       out_frame_length,
  output logic                                    out_last_byte,
  output logic                                    out_bus_idle
);
  import igfrb_pkg::*;

  localparam int LEN_W     = $clog2(FRAME_BYTES);
  localparam int SLOT_W    = $clog2(FRAME_SLOTS);
  localparam int MEM_DEPTH = FRAME_SLOTS * FRAME_BYTES;
  localparam int ADDR_W    = $clog2(MEM_DEPTH);
  localparam logic [LEN_W-1:0]  LEN_MAX   = LEN_W'(FRAME_BYTES - 1);
  localparam logic [SLOT_W-1:0] SLOT_LAST = SLOT_W'(FRAME_SLOTS - 1);

  function automatic logic [SLOT_W-1:0] next_slot(input logic [SLOT_W-1:0] s);
    next_slot = (s == SLOT_LAST) ? '0 : s + SLOT_W'(1);
  endfunction

  logic [TICK_W-1:0] idle_ticks;

  igfrb_regs u_regs (
    .clk        (clk),
    .rst_n      (rst_n),
    .psel       (psel),
    .penable    (penable),
    .pwrite     (pwrite),
    .paddr      (paddr),
    .pwdata     (pwdata),
    .prdata     (prdata),
    .pready     (pready),
    .idle_ticks (idle_ticks)
  );

  state_t state_r, state_nxt;

  logic [LEN_W-1:0]  slot_len_r   [FRAME_SLOTS];
  logic [LEN_W-1:0]  slot_len_nxt [FRAME_SLOTS];
  logic              slot_done_r   [FRAME_SLOTS];
  logic              slot_done_nxt [FRAME_SLOTS];
  logic [SLOT_W-1:0] write_slot_r, write_slot_nxt;
  logic [SLOT_W-1:0] read_slot_r, read_slot_nxt;
  logic [TICK_W-1:0] idle_count_r, idle_count_nxt;
  logic [LEN_W-1:0]  read_cursor_r, read_cursor_nxt;

  logic              pend_ready_r, pend_ready_nxt;
  logic [FLEN_W-1:0] pend_flen_r, pend_flen_nxt;
  logic              pend_last_r, pend_last_nxt;

  logic              out_valid_r, out_valid_nxt;
  logic              out_frame_ready_r, out_frame_ready_nxt;
  logic [BYTE_W-1:0] out_read_byte_r, out_read_byte_nxt;
  logic [FLEN_W-1:0] out_frame_length_r, out_frame_length_nxt;
  logic              out_last_byte_r, out_last_byte_nxt;
  logic              out_bus_idle_r, out_bus_idle_nxt;

  logic [BYTE_W-1:0] slot_mem [MEM_DEPTH];
  logic [BYTE_W-1:0] mem_rd_r;
  logic              mem_we;
  logic              mem_re;
  logic [ADDR_W-1:0] wr_addr;
  logic [ADDR_W-1:0] rd_addr;

  logic              in_acc;
  logic              read_load;
  logic [LEN_W-1:0]  w_len;
  logic [LEN_W-1:0]  base_len;
  logic [LEN_W-1:0]  r_len;
  logic [LEN_W-1:0]  rd_cur;
  logic              rd_last;
  logic [SLOT_W-1:0] w_next;
  logic [SLOT_W-1:0] r_next;
  logic [LEN_W+FLEN_W-1:0] r_len_ext;

  assign in_acc = in_valid && in_ready;

  always_comb begin
    state_nxt = state_r;
    case (state_r)
      ST_IDLE: begin
        if (in_acc && (in_cmd == CMD_READ)) begin
          state_nxt = ST_READ;
        end
      end
      ST_READ: begin
        state_nxt = ST_IDLE;
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  always_comb begin
    in_ready  = 1'b0;
    read_load = 1'b0;
    case (state_r)
      ST_IDLE: begin
        in_ready = !out_valid_r || out_ready;
      end
      ST_READ: begin
        read_load = 1'b1;
      end
      default: begin
        in_ready = 1'b0;
      end
    endcase
  end

  assign w_len     = slot_len_r[write_slot_r];
  assign base_len  = (w_len >= LEN_MAX) ? '0 : w_len;
  assign r_len     = slot_len_r[read_slot_r];
  assign rd_cur    = (read_cursor_r >= r_len) ? r_len - LEN_W'(1) : read_cursor_r;
  assign rd_last   = (rd_cur == r_len - LEN_W'(1));
  assign w_next    = next_slot(write_slot_r);
  assign r_next    = next_slot(read_slot_r);
  assign r_len_ext = {{FLEN_W{1'b0}}, r_len};
  assign wr_addr   = ADDR_W'(ADDR_W'(write_slot_r) * ADDR_W'(FRAME_BYTES) + ADDR_W'(base_len));
  assign rd_addr   = ADDR_W'(ADDR_W'(read_slot_r) * ADDR_W'(FRAME_BYTES) + ADDR_W'(rd_cur));

  always_comb begin
    idle_count_nxt  = idle_count_r;
    write_slot_nxt  = write_slot_r;
    read_slot_nxt   = read_slot_r;
    read_cursor_nxt = read_cursor_r;
    slot_len_nxt    = slot_len_r;
    slot_done_nxt   = slot_done_r;
    pend_ready_nxt  = pend_ready_r;
    pend_flen_nxt   = pend_flen_r;
    pend_last_nxt   = pend_last_r;
    mem_we          = 1'b0;
    mem_re          = 1'b0;
    if (in_acc) begin
      pend_ready_nxt = 1'b0;
      pend_flen_nxt  = '0;
      pend_last_nxt  = 1'b0;
      case (in_cmd)
        CMD_BYTE: begin
          idle_count_nxt              = idle_ticks;
          slot_done_nxt[write_slot_r] = 1'b0;
          slot_len_nxt[write_slot_r]  = base_len + LEN_W'(1);
          mem_we                      = 1'b1;
          if (write_slot_r == read_slot_r) begin
            read_cursor_nxt = '0;
          end
        end
        CMD_TICK: begin
          if (idle_count_r != '0) begin
            idle_count_nxt = idle_count_r - TICK_W'(1);
            if (idle_count_r == TICK_W'(1)) begin
              slot_done_nxt[write_slot_r] = 1'b1;
              write_slot_nxt              = w_next;
              if (read_slot_r == w_next) begin
                read_slot_nxt   = r_next;
                read_cursor_nxt = '0;
              end
            end
          end
        end
        CMD_READ: begin
          if (slot_done_r[read_slot_r]) begin
            if (r_len != '0) begin
              mem_re          = 1'b1;
              pend_ready_nxt  = 1'b1;
              pend_flen_nxt   = r_len_ext[FLEN_W-1:0];
              pend_last_nxt   = rd_last;
              read_cursor_nxt = rd_cur + LEN_W'(1);
            end
            if ((r_len == '0) || rd_last) begin
              slot_done_nxt[read_slot_r] = 1'b0;
              slot_len_nxt[read_slot_r]  = '0;
              read_slot_nxt              = r_next;
              read_cursor_nxt            = '0;
            end
          end
        end
        default: begin
          write_slot_nxt  = '0;
          read_slot_nxt   = '0;
          read_cursor_nxt = '0;
          for (int i = 0; i < FRAME_SLOTS; i++) begin
            slot_len_nxt[i]  = '0;
            slot_done_nxt[i] = 1'b0;
          end
        end
      endcase
    end
  end

  always_comb begin
    out_valid_nxt        = out_valid_r;
    out_frame_ready_nxt  = out_frame_ready_r;
    out_read_byte_nxt    = out_read_byte_r;
    out_frame_length_nxt = out_frame_length_r;
    out_last_byte_nxt    = out_last_byte_r;
    out_bus_idle_nxt     = out_bus_idle_r;
    if (out_ready) begin
      out_valid_nxt = 1'b0;
    end
    if (read_load) begin
      out_valid_nxt        = 1'b1;
      out_frame_ready_nxt  = pend_ready_r;
      out_read_byte_nxt    = pend_ready_r ? mem_rd_r : '0;
      out_frame_length_nxt = pend_flen_r;
      out_last_byte_nxt    = pend_last_r;
      out_bus_idle_nxt     = (idle_count_r == '0);
    end else if (in_acc && (in_cmd != CMD_READ)) begin
      out_valid_nxt        = 1'b1;
      out_frame_ready_nxt  = 1'b0;
      out_read_byte_nxt    = '0;
      out_frame_length_nxt = '0;
      out_last_byte_nxt    = 1'b0;
      out_bus_idle_nxt     = (idle_count_nxt == '0);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r       <= ST_IDLE;
      write_slot_r  <= '0;
      read_slot_r   <= '0;
      idle_count_r  <= '0;
      read_cursor_r <= '0;
      out_valid_r   <= 1'b0;
      for (int i = 0; i < FRAME_SLOTS; i++) begin
        slot_len_r[i]  <= '0;
        slot_done_r[i] <= 1'b0;
      end
    end else begin
      state_r       <= state_nxt;
      write_slot_r  <= write_slot_nxt;
      read_slot_r   <= read_slot_nxt;
      idle_count_r  <= idle_count_nxt;
      read_cursor_r <= read_cursor_nxt;
      out_valid_r   <= out_valid_nxt;
      slot_len_r    <= slot_len_nxt;
      slot_done_r   <= slot_done_nxt;
    end
  end

  always_ff @(posedge clk) begin
    pend_ready_r       <= pend_ready_nxt;
    pend_flen_r        <= pend_flen_nxt;
    pend_last_r        <= pend_last_nxt;
    out_frame_ready_r  <= out_frame_ready_nxt;
    out_read_byte_r    <= out_read_byte_nxt;
    out_frame_length_r <= out_frame_length_nxt;
    out_last_byte_r    <= out_last_byte_nxt;
    out_bus_idle_r     <= out_bus_idle_nxt;
  end

  always_ff @(posedge clk) begin
    if (mem_we) begin
      slot_mem[wr_addr] <= in_rx_byte;
    end
    if (mem_re) begin
      mem_rd_r <= slot_mem[rd_addr];
    end
  end

  assign out_valid        = out_valid_r;
  assign out_frame_ready  = out_frame_ready_r;
  assign out_read_byte    = out_read_byte_r;
  assign out_frame_length = out_frame_length_r;
  assign out_last_byte    = out_last_byte_r;
  assign out_bus_idle     = out_bus_idle_r;

  a_read_completes: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ST_READ) |=> (state_r == ST_IDLE) && out_valid_r)
    else $error("Read command did not deliver its result word.");

  a_other_cmd_result: assert property (@(posedge clk) disable iff (!rst_n)
    (in_acc && (in_cmd != CMD_READ)) |=> out_valid_r)
    else $error("Non-read command did not deliver its result word.");

  a_no_accept_in_read: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ST_READ) |-> !in_ready)
    else $error("Command word accepted while a memory read is pending.");

  a_cursor_in_frame: assert property (@(posedge clk) disable iff (!rst_n)
    read_cursor_r <= slot_len_r[read_slot_r])
    else $error("Read cursor is beyond the length of the read slot.");

  a_last_has_data: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && out_last_byte_r) |-> out_frame_ready_r)
    else $error("Last-byte flag set on a word without frame data.");

endmodule : idle_gap_frame_ring_buffer
`default_nettype wire
